@@ design/dmpl_pkg.sv @@
// Shared types, constants and helper functions for the dual motor PWM limiter.
`default_nettype none
package dmpl_pkg;

  // Internal signed width of drive values (covers +/-765 slew differences)
  localparam int unsigned VAL_W = 12;
  // Width of the kept drive value
  localparam int unsigned LAST_W = 11;
  // Width of a reported drive value
  localparam int unsigned PWM_W = 10;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef enum logic [1:0] {
    ACT_DRIVE   = 2'd0,
    ACT_BATTERY = 2'd1,
    ACT_CLEAR   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    LVL_OK   = 2'd0,
    LVL_LOW  = 2'd1,
    LVL_CRIT = 2'd2
  } batt_level_e;

  localparam logic [1:0] KICK_OFF     = 2'd0;
  localparam logic [1:0] KICK_ON      = 2'd1;
  localparam logic [1:0] KICK_OK_ONLY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BATT_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAPS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBANDS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KICK_MODE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KICK_BOOST = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KICK_TICKS = 3'd7;

  localparam logic [31:0] RST_BATT_THR   = 32'h1900_1B58;  // LOW 6400, OK 7000
  localparam logic [31:0] RST_ACCEL      = 32'h0005_0A0F;
  localparam logic [31:0] RST_DECEL      = 32'h000A_141E;
  localparam logic [31:0] RST_CAPS       = 32'h0096_C8FF;
  localparam logic [15:0] RST_DEADBANDS  = 16'h2828;
  localparam logic [1:0]  RST_KICK_MODE  = KICK_OK_ONLY;
  localparam logic [7:0]  RST_KICK_BOOST = 8'd20;
  localparam logic [7:0]  RST_KICK_TICKS = 8'd10;

  typedef struct packed {
    logic [31:0] batt_thr;
    logic [31:0] accel;
    logic [31:0] decel;
    logic [31:0] caps;
    logic [15:0] deadbands;
    logic [1:0]  kick_mode;
    logic [7:0]  kick_boost;
    logic [7:0]  kick_ticks;
  } cfg_t;

  // Per-channel settings resolved for the current battery level
  typedef struct packed {
    logic [7:0] cap;
    logic [7:0] up;
    logic [7:0] down;
    logic [7:0] db;
    logic [7:0] boost;
    logic [7:0] ticks;
  } chan_cfg_t;

  function automatic logic [7:0] pick_byte(input logic [31:0] packed_w,
                                           input logic [1:0] level);
    logic [7:0] sel;
    case (level)
      LVL_LOW:  sel = packed_w[15:8];
      LVL_CRIT: sel = packed_w[23:16];
      default:  sel = packed_w[7:0];
    endcase
    return (packed_w[31:24] != 8'd0) ? packed_w[31:24] : sel;
  endfunction

  function automatic logic [VAL_W-1:0] mag(input logic signed [VAL_W-1:0] v);
    return v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
  endfunction

endpackage
`default_nettype wire

@@ design/dmpl_cfg_regs.sv @@
// Configuration register file of the dual motor PWM limiter.
`default_nettype none
module dmpl_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                we_i,
  input  logic [dmpl_pkg::CFG_IDX_W-1:0]      index_i,
  input  logic [dmpl_pkg::CFG_DATA_W-1:0]     wdata_i,
  output dmpl_pkg::cfg_t                      cfg_o
);
  import dmpl_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.batt_thr   <= RST_BATT_THR;
      cfg_q.accel      <= RST_ACCEL;
      cfg_q.decel      <= RST_DECEL;
      cfg_q.caps       <= RST_CAPS;
      cfg_q.deadbands  <= RST_DEADBANDS;
      cfg_q.kick_mode  <= RST_KICK_MODE;
      cfg_q.kick_boost <= RST_KICK_BOOST;
      cfg_q.kick_ticks <= RST_KICK_TICKS;
    end else if (we_i) begin
      case (index_i)
        REG_BATT_THR:   cfg_q.batt_thr   <= wdata_i;
        REG_ACCEL:      cfg_q.accel      <= wdata_i;
        REG_DECEL:      cfg_q.decel      <= wdata_i;
        REG_CAPS:       cfg_q.caps       <= wdata_i;
        REG_DEADBANDS:  cfg_q.deadbands  <= wdata_i[15:0];
        REG_KICK_MODE:  cfg_q.kick_mode  <= wdata_i[1:0];
        REG_KICK_BOOST: cfg_q.kick_boost <= wdata_i[7:0];
        REG_KICK_TICKS: cfg_q.kick_ticks <= wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ design/dmpl_channel.sv @@
// One drive channel: cap, slew limit, kick boost and deadband lift.
`default_nettype none
module dmpl_channel (
  input  logic signed [15:0]                  target_i,
  input  logic signed [dmpl_pkg::LAST_W-1:0]  cur_i,
  input  dmpl_pkg::chan_cfg_t                 cfg_i,
  input  logic                                kick_on_i,
  input  logic [7:0]                          tick_i,
  input  logic [7:0]                          end_i,
  output logic signed [dmpl_pkg::LAST_W-1:0]  next_o,
  output logic [7:0]                          end_o
);
  import dmpl_pkg::*;

  logic signed [16:0]      tgt_w;
  logic signed [16:0]      cap_w;
  logic signed [VAL_W-1:0] cap_v;
  logic signed [VAL_W-1:0] tgt_c;
  logic signed [VAL_W-1:0] cur_x;
  logic signed [VAL_W-1:0] diff;
  logic [VAL_W-1:0]        step;
  logic                    accel;
  logic signed [VAL_W-1:0] slewed;
  logic [VAL_W-1:0]        mag_s;
  logic [VAL_W-1:0]        kmag;
  logic signed [VAL_W-1:0] boosted;
  logic [7:0]              elapsed;
  logic                    held;
  logic signed [VAL_W-1:0] kicked;
  logic [VAL_W-1:0]        mag_k;
  logic [VAL_W-1:0]        db_x;
  logic signed [VAL_W-1:0] lifted;

  // magnitude cap
  always_comb begin
    tgt_w = {target_i[15], target_i};
    cap_w = {9'd0, cfg_i.cap};
    cap_v = $signed({4'd0, cfg_i.cap});
    if (tgt_w > cap_w) begin
      tgt_c = cap_v;
    end else if (tgt_w < -cap_w) begin
      tgt_c = -cap_v;
    end else begin
      tgt_c = tgt_w[VAL_W-1:0];
    end
  end

  // slew limit; a stop or a reversal uses the decel step
  assign cur_x = VAL_W'(cur_i);
  assign diff  = tgt_c - cur_x;

  always_comb begin
    if (tgt_c == '0) begin
      accel = 1'b0;
    end else if (cur_x == '0) begin
      accel = 1'b1;
    end else if (tgt_c[VAL_W-1] == cur_x[VAL_W-1]) begin
      accel = mag(tgt_c) > mag(cur_x);
    end else begin
      accel = 1'b0;
    end
    step = {4'd0, (accel ? cfg_i.up : cfg_i.down)};
    if (mag(diff) <= step) begin
      slewed = tgt_c;
    end else if (!diff[VAL_W-1]) begin
      slewed = cur_x + $signed(step);
    end else begin
      slewed = cur_x - $signed(step);
    end
  end

  // kick boost on a start from zero
  assign mag_s   = mag(slewed);
  assign kmag    = {4'd0, cfg_i.db} + {4'd0, cfg_i.boost};
  assign boosted = slewed[VAL_W-1] ? -$signed(kmag) : $signed(kmag);
  assign elapsed = tick_i - end_i + cfg_i.ticks;

  always_comb begin
    kicked = slewed;
    end_o  = end_i;
    held   = 1'b0;
    if (kick_on_i) begin
      if (end_i != 8'd0) begin
        if (elapsed >= cfg_i.ticks) begin
          end_o = 8'd0;
        end else if (slewed != '0 && mag_s < kmag) begin
          kicked = boosted;
          held   = 1'b1;
        end
      end
      if (!held && cur_x == '0 && slewed != '0 && end_o == 8'd0) begin
        end_o = tick_i + cfg_i.ticks;
        if (mag_s < kmag) begin
          kicked = boosted;
        end
      end
    end
  end

  // deadband lift of small nonzero values
  assign mag_k = mag(kicked);
  assign db_x  = {4'd0, cfg_i.db};

  always_comb begin
    if (kicked == '0) begin
      lifted = '0;
    end else if (mag_k < db_x) begin
      lifted = kicked[VAL_W-1] ? -$signed(db_x) : $signed(db_x);
    end else begin
      lifted = kicked;
    end
  end

  assign next_o = lifted[LAST_W-1:0];

endmodule
`default_nettype wire

@@ design/dual_motor_pwm_safety_limiter.sv @@
// Top level of the battery-aware dual motor PWM slew and deadband limiter.
// Usage:
//  - Input stream (s_axis_*): one transaction per command. tuser carries the
//    action: drive, battery update or clear of slew and kick state.
//    tdata carries left target, right target and battery voltage.
//  - Output stream (m_axis_*): exactly one result transaction per command,
//    giving both drive values, the battery level and both kick flags.
//  - Configuration: plain write port (cfg_we_i, cfg_index_i, cfg_wdata_i),
//    one register per cycle; the user must write it only while no command
//    is in flight. The block does not enforce this.
//  - Path: an accepted command waits in the input register, then passes
//    the channel logic into the result register.
//  - Throughput: one command per cycle while the output is not stalled.
//    The state update (slew, kick, tick, battery level) is registered with
//    the result, so back-to-back commands see the previous state.
//  - Stall: a waiting result holds while m_axis_tready is low; the input
//    register still takes one more transaction, then s_axis_tready drops.
//  - Reset (rst_ni low, asynchronous): config registers return to their
//    defaults, battery level OK, tick and drive values zero, kicks inactive,
//    both streams empty.
`default_nettype none
module dual_motor_pwm_safety_limiter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config write port
  input  logic                                 cfg_we_i,
  input  logic [dmpl_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dmpl_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // command stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: left_target[15:0], right_target[31:16], battery_mv[47:32]
  input  logic [dmpl_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // tuser: action[1:0]
  input  logic [dmpl_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: left_pwm[9:0], right_pwm[19:10], battery_level[21:20],
  //        kick_left_active[22], kick_right_active[23]
  output logic [dmpl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import dmpl_pkg::*;

  cfg_t cfg;

  dmpl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // input register
  logic                        in_valid_q;
  logic [IN_TUSER_W-1:0]       in_action_q;
  logic signed [15:0]          in_left_q;
  logic signed [15:0]          in_right_q;
  logic [15:0]                 in_mv_q;

  // block state
  logic [1:0]                  level_q, level_d;
  logic [7:0]                  tick_q, tick_d;
  logic signed [LAST_W-1:0]    last_l_q, last_l_d;
  logic signed [LAST_W-1:0]    last_r_q, last_r_d;
  logic [7:0]                  end_l_q, end_l_d;
  logic [7:0]                  end_r_q, end_r_d;

  // result register
  logic                        out_valid_q;
  logic [OUT_TDATA_W-1:0]      out_data_q;

  logic                        in_take;
  logic                        stage_go;

  assign stage_go      = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || stage_go;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // per-level settings shared by both channels
  chan_cfg_t   cfg_l, cfg_r;
  logic [7:0]  cap_sel, up_sel, down_sel;
  logic        kick_on;
  logic [7:0]  tick_inc;
  logic signed [LAST_W-1:0] chan_l, chan_r;
  logic [7:0]  chan_end_l, chan_end_r;

  assign cap_sel  = pick_byte(cfg.caps, level_q);
  assign up_sel   = pick_byte(cfg.accel, level_q);
  assign down_sel = pick_byte(cfg.decel, level_q);
  assign tick_inc = tick_q + 8'd1;

  always_comb begin
    case (cfg.kick_mode)
      KICK_ON:      kick_on = 1'b1;
      KICK_OK_ONLY: kick_on = (level_q == LVL_OK);
      default:      kick_on = 1'b0;
    endcase
  end

  always_comb begin
    cfg_l.cap   = cap_sel;
    cfg_l.up    = up_sel;
    cfg_l.down  = down_sel;
    cfg_l.db    = cfg.deadbands[7:0];
    cfg_l.boost = cfg.kick_boost;
    cfg_l.ticks = cfg.kick_ticks;
    cfg_r       = cfg_l;
    cfg_r.db    = cfg.deadbands[15:8];
  end

  dmpl_channel u_left (
    .target_i  (in_left_q),
    .cur_i     (last_l_q),
    .cfg_i     (cfg_l),
    .kick_on_i (kick_on),
    .tick_i    (tick_inc),
    .end_i     (end_l_q),
    .next_o    (chan_l),
    .end_o     (chan_end_l)
  );

  dmpl_channel u_right (
    .target_i  (in_right_q),
    .cur_i     (last_r_q),
    .cfg_i     (cfg_r),
    .kick_on_i (kick_on),
    .tick_i    (tick_inc),
    .end_i     (end_r_q),
    .next_o    (chan_r),
    .end_o     (chan_end_r)
  );

  // next state by action; an unused action leaves everything alone
  always_comb begin
    level_d  = level_q;
    tick_d   = tick_q;
    last_l_d = last_l_q;
    last_r_d = last_r_q;
    end_l_d  = end_l_q;
    end_r_d  = end_r_q;
    case (action_e'(in_action_q))
      ACT_DRIVE: begin
        tick_d   = tick_inc;
        last_l_d = chan_l;
        last_r_d = chan_r;
        end_l_d  = chan_end_l;
        end_r_d  = chan_end_r;
      end
      ACT_BATTERY: begin
        if (in_mv_q >= cfg.batt_thr[15:0]) begin
          level_d = LVL_OK;
        end else if (in_mv_q >= cfg.batt_thr[31:16]) begin
          level_d = LVL_LOW;
        end else begin
          level_d = LVL_CRIT;
        end
      end
      ACT_CLEAR: begin
        last_l_d = '0;
        last_r_d = '0;
        end_l_d  = 8'd0;
        end_r_d  = 8'd0;
      end
      default: ;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      level_q     <= LVL_OK;
      tick_q      <= 8'd0;
      last_l_q    <= '0;
      last_r_q    <= '0;
      end_l_q     <= 8'd0;
      end_r_q     <= 8'd0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (stage_go) begin
        in_valid_q <= 1'b0;
      end
      if (stage_go) begin
        out_valid_q <= 1'b1;
        level_q     <= level_d;
        tick_q      <= tick_d;
        last_l_q    <= last_l_d;
        last_r_q    <= last_r_d;
        end_l_q     <= end_l_d;
        end_r_q     <= end_r_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_action_q <= s_axis_tuser;
      in_left_q   <= s_axis_tdata[15:0];
      in_right_q  <= s_axis_tdata[31:16];
      in_mv_q     <= s_axis_tdata[47:32];
    end
    if (stage_go) begin
      out_data_q <= {(end_r_d != 8'd0), (end_l_d != 8'd0), level_d,
                     last_r_d[PWM_W-1:0], last_l_d[PWM_W-1:0]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire
